// ===== sv/sfla_pkg.sv =====
// Package: shared constants, memory request type and sizing functions for the allocator.
`timescale 1ns / 1ps
package sfla_pkg;

   // default sizing
   localparam int unsigned HEAP_BYTES_DEF  = 65536;
   localparam int unsigned CHUNK_BYTES_DEF = 4096;
   localparam int unsigned SIZE_CLASSES    = 9;

   // command codes
   localparam logic [1:0] CMD_INIT  = 2'd0;
   localparam logic [1:0] CMD_ALLOC = 2'd1;
   localparam logic [1:0] CMD_FREE  = 2'd2;
   localparam logic [1:0] CMD_NOP   = 2'd3;

   // status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_ZERO     = 2'd1;
   localparam logic [1:0] ST_NO_HEAP  = 2'd2;
   localparam logic [1:0] ST_NOT_INIT = 2'd3;

   // fixed layout: prologue header/footer, first epilogue, first break
   localparam logic [31:0] PRO_HDR_ADDR = 32'd36;
   localparam logic [31:0] PRO_FTR_ADDR = 32'd40;
   localparam logic [31:0] EPI_ADDR     = 32'd44;
   localparam logic [31:0] PRO_TAG      = 32'd9;
   localparam logic [31:0] EPI_TAG      = 32'd1;
   localparam int unsigned FIRST_BREAK  = 48;
   localparam logic [31:0] MIN_SPLIT    = 32'd16;

   // one access to the heap memory per cycle
   typedef struct packed {
      logic        rd;
      logic        wr;
      logic [31:0] byte_addr;
      logic [31:0] wdata;
   } mem_req_type;

   // size class: up to 32, 64 ... 4096, larger
   function automatic logic [3:0] class_of(input logic [31:0] size);
      logic [3:0] c;
      c = 4'd0;
      for (int i = 0; i < SIZE_CLASSES - 1; i++) begin
         if (size > (32'd32 << i)) begin
            c = 4'(i + 1);
         end
      end
      return c;
   endfunction

   // bytes added by a heap extension: word count rounded up to even
   function automatic logic [31:0] grow_bytes(input logic [31:0] v);
      return {v[31:2], 2'b00} + (v[2] ? 32'd4 : 32'd0);
   endfunction

   // size field of a boundary tag
   function automatic logic [31:0] tag_size(input logic [31:0] w);
      return {w[31:3], 3'b000};
   endfunction

endpackage

// ===== sv/sfla_if.sv =====
// Interfaces: request and response channels of the allocator.
`timescale 1ns / 1ps
interface sfla_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [15:0] request_size;
   logic [15:0] block_address;
   modport source (output valid, command, request_size, block_address, input ready);
   modport sink   (input valid, command, request_size, block_address, output ready);
endinterface

interface sfla_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] address;
   logic [1:0]  status;
   modport source (output valid, address, status, input ready);
   modport sink   (input valid, address, status, output ready);
endinterface

// ===== sv/sfla_mem.sv =====
// Heap word memory: one access per cycle, registered read data.
`timescale 1ns / 1ps
module sfla_mem #(
   parameter int unsigned WORD_AW = 14
) (
   input  logic                 clock,
   input  sfla_pkg::mem_req_type mreq,
   output logic [31:0]          rdata
);

   logic [31:0] mem [2**WORD_AW];
   logic [WORD_AW-1:0] idx;

   assign idx = mreq.byte_addr[WORD_AW+1:2];

   always_ff @(posedge clock) begin
      if (mreq.wr) begin
         mem[idx] <= mreq.wdata;
      end
      if (mreq.rd) begin
         rdata <= mem[idx];
      end
   end

endmodule

// ===== sv/segregated_free_list_allocator_core.sv =====
// Top level: boundary-tag heap allocator sequencer around the heap word memory.
`timescale 1ns / 1ps
// Heap allocator with nine segregated free lists kept in its own word memory.
// One command is taken at a time; the next word is accepted while a finished
// response still waits on rsp_chan. Each step does at most one read or one write
// of the single-port heap memory, so a command's time is set by its steps.
// A no-op or an ignored free goes straight to the response; a free takes longer
// the more neighbours merge with it. An allocate takes longer with each free block
// visited and each list found empty in the search; placing costs least for a whole
// block, more for a split and most when the split remainder merges with the block
// after it, and a heap extension adds its own steps. The memory is not cleared
// after reset; init lays out the list heads and tags before anything reads them.
module segregated_free_list_allocator_core #(
   parameter int unsigned HEAP_BYTES  = sfla_pkg::HEAP_BYTES_DEF,
   parameter int unsigned CHUNK_BYTES = sfla_pkg::CHUNK_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   sfla_req_if.sink   req_chan,
   sfla_rsp_if.source rsp_chan
);

   localparam int unsigned WORD_AW    = $clog2(HEAP_BYTES / 4);
   localparam int unsigned BRK_W      = $clog2(HEAP_BYTES) + 1;
   localparam int unsigned WALK_LIMIT = HEAP_BYTES / 16;
   localparam int unsigned VIS_W      = $clog2(WALK_LIMIT + 1);

   // sequencer states
   localparam logic [5:0] S_IDLE = 6'd0,  S_DISP = 6'd1,  S_I_CLR = 6'd2, S_I_P1 = 6'd3;
   localparam logic [5:0] S_I_P2 = 6'd4,  S_I_EP = 6'd5,  S_I_OK = 6'd6,  S_G0 = 6'd7;
   localparam logic [5:0] S_G1 = 6'd8,    S_G2 = 6'd9,    S_G3 = 6'd10,   S_F0 = 6'd11;
   localparam logic [5:0] S_F1 = 6'd12,   S_F2 = 6'd13,   S_MISS = 6'd14, S_P0 = 6'd15;
   localparam logic [5:0] S_PC = 6'd16,   S_P2 = 6'd17,   S_P3 = 6'd18,   S_P4 = 6'd19;
   localparam logic [5:0] S_P5 = 6'd20,   S_P6 = 6'd21,   S_FR0 = 6'd22,  S_FR1 = 6'd23;
   localparam logic [5:0] S_FR2 = 6'd24,  S_MG0 = 6'd25,  S_MG1 = 6'd26,  S_MG2 = 6'd27;
   localparam logic [5:0] S_MG3 = 6'd28,  S_MG4 = 6'd29,  S_MA0 = 6'd30,  S_MA1 = 6'd31;
   localparam logic [5:0] S_MA2 = 6'd32,  S_MB0 = 6'd33,  S_MB1 = 6'd34,  S_MB2 = 6'd35;
   localparam logic [5:0] S_MB3 = 6'd36,  S_MC0 = 6'd37,  S_MC1 = 6'd38,  S_MC2 = 6'd39;
   localparam logic [5:0] S_MC3 = 6'd40,  S_MC4 = 6'd41,  S_MC5 = 6'd42,  S_MADD = 6'd43;
   localparam logic [5:0] S_R0 = 6'd44,   S_R1 = 6'd45,   S_R2 = 6'd46,   S_R3 = 6'd47;
   localparam logic [5:0] S_R4 = 6'd48,   S_R5 = 6'd49,   S_R6 = 6'd50,   S_A0 = 6'd51;
   localparam logic [5:0] S_A1 = 6'd52,   S_A2 = 6'd53,   S_A3 = 6'd54,   S_A4 = 6'd55;
   localparam logic [5:0] S_A5 = 6'd56,   S_DONE = 6'd57;

   sfla_pkg::mem_req_type mreq;
   logic [31:0] rdata, dsz;

   logic [5:0]       state_ff, state_in, ret_rm_ff, ret_rm_in;
   logic [5:0]       ret_add_ff, ret_add_in, ret_mg_ff, ret_mg_in, gret_ff, gret_in;
   logic [1:0]       cmd_ff, cmd_in, st_ff, st_in;
   logic [15:0]      req_ff, req_in, addr_ff, addr_in, res_ff, res_in;
   logic [16:0]      asize_ff, asize_in;
   logic [BRK_W-1:0] brk_ff, brk_in;
   logic             ready_ff, ready_in, pa_ff, pa_in;
   logic [3:0]       cls_ff, cls_in, icnt_ff, icnt_in;
   logic [VIS_W-1:0] vis_ff, vis_in;
   logic [31:0]      fbp_ff, fbp_in, cur_ff, cur_in, rbp_ff, rbp_in, nx_ff, nx_in;
   logic [31:0]      pv_ff, pv_in, abp_ff, abp_in, first_ff, first_in, mbp_ff, mbp_in;
   logic [31:0]      pb_ff, pb_in, nb_ff, nb_in, msz_ff, msz_in, tmp_ff, tmp_in;
   logic [31:0]      gsz_ff, gsz_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [15:0]      rsp_addr_ff, rsp_addr_in;
   logic [1:0]       rsp_st_ff, rsp_st_in;

   // derived values used by several steps
   logic [31:0] asize32, head_addr, ext, rem, hdr_tag;
   logic [3:0]  d_cls;
   logic        grow_fail;

   sfla_mem #(.WORD_AW(WORD_AW)) u_mem (
      .clock (clock),
      .mreq  (mreq),
      .rdata (rdata)
   );

   assign dsz       = sfla_pkg::tag_size(rdata);
   assign d_cls     = sfla_pkg::class_of(dsz);
   assign asize32   = 32'(asize_ff);
   assign head_addr = 32'({cls_ff, 2'b00});
   assign ext       = (asize32 > 32'(CHUNK_BYTES)) ? asize32 : 32'(CHUNK_BYTES);
   assign rem       = cur_ff - asize32;
   assign hdr_tag   = asize32 | 32'd1;
   assign grow_fail = (33'(brk_ff) > 33'(HEAP_BYTES))
                   || (33'(gsz_ff) > (33'(HEAP_BYTES) - 33'(brk_ff)));

   assign req_chan.ready = (state_ff == S_IDLE);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.address = rsp_addr_ff;
   assign rsp_chan.status  = rsp_st_ff;

   // sequencer: at most one memory read or write per step
   always_comb begin
      state_in = state_ff;   ret_rm_in = ret_rm_ff;  ret_add_in = ret_add_ff;
      ret_mg_in = ret_mg_ff; gret_in = gret_ff;      cmd_in = cmd_ff;
      st_in = st_ff;         req_in = req_ff;        addr_in = addr_ff;
      res_in = res_ff;       asize_in = asize_ff;    brk_in = brk_ff;
      ready_in = ready_ff;   pa_in = pa_ff;          cls_in = cls_ff;
      icnt_in = icnt_ff;     vis_in = vis_ff;        fbp_in = fbp_ff;
      cur_in = cur_ff;       rbp_in = rbp_ff;        nx_in = nx_ff;
      pv_in = pv_ff;         abp_in = abp_ff;        first_in = first_ff;
      mbp_in = mbp_ff;       pb_in = pb_ff;          nb_in = nb_ff;
      msz_in = msz_ff;       tmp_in = tmp_ff;        gsz_in = gsz_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_chan.ready;
      rsp_addr_in = rsp_addr_ff; rsp_st_in = rsp_st_ff;
      mreq = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               cmd_in   = req_chan.command;
               req_in   = req_chan.request_size;
               addr_in  = req_chan.block_address;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            res_in   = 16'd0;
            st_in    = sfla_pkg::ST_OK;
            state_in = S_DONE;
            unique case (cmd_ff)
               sfla_pkg::CMD_INIT: begin
                  ready_in = 1'b0;
                  brk_in   = BRK_W'(sfla_pkg::FIRST_BREAK);
                  icnt_in  = 4'd0;
                  state_in = S_I_CLR;
               end
               sfla_pkg::CMD_ALLOC: begin
                  if (!ready_ff) begin
                     st_in = sfla_pkg::ST_NOT_INIT;
                  end else if (req_ff == 16'd0) begin
                     st_in = sfla_pkg::ST_ZERO;
                  end else begin
                     asize_in = (req_ff <= 16'd8) ? 17'd16
                              : ((17'(req_ff) + 17'd15) & ~17'd7);
                     state_in = S_F0;
                  end
               end
               sfla_pkg::CMD_FREE: begin
                  if (!ready_ff) begin
                     st_in = sfla_pkg::ST_NOT_INIT;
                  end else if (addr_ff != 16'd0 && 33'(addr_ff) < 33'(brk_ff)) begin
                     state_in = S_FR0;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end

         // init: list heads, prologue, epilogue, first chunk
         S_I_CLR: begin
            mreq.wr = 1'b1; mreq.byte_addr = 32'({icnt_ff, 2'b00}); mreq.wdata = 32'd0;
            icnt_in = icnt_ff + 4'd1;
            if (icnt_ff == 4'(sfla_pkg::SIZE_CLASSES - 1)) state_in = S_I_P1;
         end
         S_I_P1: begin
            mreq.wr = 1'b1; mreq.byte_addr = sfla_pkg::PRO_HDR_ADDR;
            mreq.wdata = sfla_pkg::PRO_TAG; state_in = S_I_P2;
         end
         S_I_P2: begin
            mreq.wr = 1'b1; mreq.byte_addr = sfla_pkg::PRO_FTR_ADDR;
            mreq.wdata = sfla_pkg::PRO_TAG; state_in = S_I_EP;
         end
         S_I_EP: begin
            mreq.wr = 1'b1; mreq.byte_addr = sfla_pkg::EPI_ADDR;
            mreq.wdata = sfla_pkg::EPI_TAG;
            gsz_in = sfla_pkg::grow_bytes(32'(CHUNK_BYTES));
            gret_in = S_I_OK; state_in = S_G0;
         end
         S_I_OK: begin
            ready_in = 1'b1; state_in = S_DONE;
         end

         // heap extension: new free block at the break
         S_G0: begin
            if (grow_fail) begin
               st_in = sfla_pkg::ST_NO_HEAP; state_in = S_DONE;
            end else begin
               fbp_in = 32'(brk_ff);
               brk_in = brk_ff + BRK_W'(gsz_ff);
               state_in = S_G1;
            end
         end
         S_G1: begin
            mreq.wr = 1'b1; mreq.byte_addr = fbp_ff - 32'd4; mreq.wdata = gsz_ff;
            state_in = S_G2;
         end
         S_G2: begin
            mreq.wr = 1'b1; mreq.byte_addr = fbp_ff + gsz_ff - 32'd8; mreq.wdata = gsz_ff;
            state_in = S_G3;
         end
         S_G3: begin
            mreq.wr = 1'b1; mreq.byte_addr = fbp_ff + gsz_ff - 32'd4;
            mreq.wdata = sfla_pkg::EPI_TAG;
            abp_in = fbp_ff; ret_add_in = gret_ff; state_in = S_A0;
         end

         // first-fit search from the request's class upward
         S_F0: begin
            cls_in = sfla_pkg::class_of(asize32);
            vis_in = '0;
            mreq.rd = 1'b1;
            mreq.byte_addr = 32'({sfla_pkg::class_of(asize32), 2'b00});
            state_in = S_F1;
         end
         S_F1: begin
            if (rdata == 32'd0) begin
               if (cls_ff == 4'(sfla_pkg::SIZE_CLASSES - 1)) begin
                  state_in = S_MISS;
               end else begin
                  cls_in = cls_ff + 4'd1;
                  mreq.rd = 1'b1; mreq.byte_addr = 32'({cls_ff + 4'd1, 2'b00});
               end
            end else if (vis_ff >= VIS_W'(WALK_LIMIT)) begin
               state_in = S_MISS;
            end else begin
               vis_in = vis_ff + VIS_W'(1);
               fbp_in = rdata;
               mreq.rd = 1'b1; mreq.byte_addr = rdata - 32'd4;
               state_in = S_F2;
            end
         end
         S_F2: begin
            if (dsz >= asize32) begin
               cur_in = dsz; rbp_in = fbp_ff; ret_rm_in = S_P2; state_in = S_R0;
            end else begin
               mreq.rd = 1'b1; mreq.byte_addr = fbp_ff; state_in = S_F1;
            end
         end
         S_MISS: begin
            gsz_in = sfla_pkg::grow_bytes(ext); gret_in = S_P0; state_in = S_G0;
         end

         // place: unlink, then split or take whole
         S_P0: begin
            mreq.rd = 1'b1; mreq.byte_addr = fbp_ff - 32'd4; state_in = S_PC;
         end
         S_PC: begin
            cur_in = dsz; rbp_in = fbp_ff; ret_rm_in = S_P2; state_in = S_R0;
         end
         S_P2: begin
            res_in = fbp_ff[15:0];
            mreq.wr = 1'b1; mreq.byte_addr = fbp_ff - 32'd4;
            if (rem >= sfla_pkg::MIN_SPLIT) begin
               mreq.wdata = hdr_tag; state_in = S_P3;
            end else begin
               mreq.wdata = cur_ff | 32'd1; state_in = S_P6;
            end
         end
         S_P3: begin
            mreq.wr = 1'b1; mreq.byte_addr = fbp_ff + asize32 - 32'd8;
            mreq.wdata = hdr_tag; state_in = S_P4;
         end
         S_P4: begin
            mreq.wr = 1'b1; mreq.byte_addr = fbp_ff + asize32 - 32'd4;
            mreq.wdata = rem; state_in = S_P5;
         end
         S_P5: begin
            mreq.wr = 1'b1; mreq.byte_addr = fbp_ff + asize32 + rem - 32'd8;
            mreq.wdata = rem;
            mbp_in = fbp_ff + asize32; ret_mg_in = S_DONE; state_in = S_MG0;
         end
         S_P6: begin
            mreq.wr = 1'b1; mreq.byte_addr = fbp_ff + cur_ff - 32'd8;
            mreq.wdata = cur_ff | 32'd1; state_in = S_DONE;
         end

         // free: clear the allocated bits, then merge
         S_FR0: begin
            mreq.rd = 1'b1; mreq.byte_addr = 32'(addr_ff) - 32'd4; state_in = S_FR1;
         end
         S_FR1: begin
            tmp_in = dsz;
            mreq.wr = 1'b1; mreq.byte_addr = 32'(addr_ff) - 32'd4; mreq.wdata = dsz;
            state_in = S_FR2;
         end
         S_FR2: begin
            mreq.wr = 1'b1; mreq.byte_addr = 32'(addr_ff) + tmp_ff - 32'd8;
            mreq.wdata = tmp_ff;
            mbp_in = 32'(addr_ff); ret_mg_in = S_DONE; state_in = S_MG0;
         end

         // merge with free neighbours
         S_MG0: begin
            mreq.rd = 1'b1; mreq.byte_addr = mbp_ff - 32'd8; state_in = S_MG1;
         end
         S_MG1: begin
            pb_in = mbp_ff - dsz;
            mreq.rd = 1'b1; mreq.byte_addr = mbp_ff - 32'd4; state_in = S_MG2;
         end
         S_MG2: begin
            msz_in = dsz; nb_in = mbp_ff + dsz;
            mreq.rd = 1'b1; mreq.byte_addr = pb_ff - 32'd4; state_in = S_MG3;
         end
         S_MG3: begin
            pa_in = rdata[0];
            mreq.rd = 1'b1; mreq.byte_addr = nb_ff - 32'd4; state_in = S_MG4;
         end
         S_MG4: begin
            priority if (pa_ff && !rdata[0]) begin
               rbp_in = nb_ff; ret_rm_in = S_MA0; state_in = S_R0;
            end else if (!pa_ff && rdata[0]) begin
               rbp_in = pb_ff; ret_rm_in = S_MB0; state_in = S_R0;
            end else if (!pa_ff && !rdata[0]) begin
               rbp_in = pb_ff; ret_rm_in = S_MC0; state_in = S_R0;
            end else begin
               state_in = S_MADD;
            end
         end
         S_MA0: begin
            mreq.rd = 1'b1; mreq.byte_addr = nb_ff - 32'd4; state_in = S_MA1;
         end
         S_MA1: begin
            msz_in = msz_ff + dsz;
            mreq.wr = 1'b1; mreq.byte_addr = nb_ff + dsz - 32'd8;
            mreq.wdata = msz_ff + dsz; state_in = S_MA2;
         end
         S_MA2: begin
            mreq.wr = 1'b1; mreq.byte_addr = mbp_ff - 32'd4; mreq.wdata = msz_ff;
            state_in = S_MADD;
         end
         S_MB0: begin
            mreq.rd = 1'b1; mreq.byte_addr = pb_ff - 32'd4; state_in = S_MB1;
         end
         S_MB1: begin
            msz_in = msz_ff + dsz;
            mreq.rd = 1'b1; mreq.byte_addr = mbp_ff - 32'd4; state_in = S_MB2;
         end
         S_MB2: begin
            mreq.wr = 1'b1; mreq.byte_addr = mbp_ff + dsz - 32'd8; mreq.wdata = msz_ff;
            state_in = S_MB3;
         end
         S_MB3: begin
            mreq.wr = 1'b1; mreq.byte_addr = pb_ff - 32'd4; mreq.wdata = msz_ff;
            mbp_in = pb_ff; state_in = S_MADD;
         end
         S_MC0: begin
            rbp_in = nb_ff; ret_rm_in = S_MC1; state_in = S_R0;
         end
         S_MC1: begin
            mreq.rd = 1'b1; mreq.byte_addr = pb_ff - 32'd4; state_in = S_MC2;
         end
         S_MC2: begin
            tmp_in = dsz;
            mreq.rd = 1'b1; mreq.byte_addr = nb_ff - 32'd4; state_in = S_MC3;
         end
         S_MC3: begin
            msz_in = msz_ff + (tmp_ff + dsz);
            mreq.wr = 1'b1; mreq.byte_addr = pb_ff - 32'd4;
            mreq.wdata = msz_ff + (tmp_ff + dsz); state_in = S_MC4;
         end
         S_MC4: begin
            mreq.rd = 1'b1; mreq.byte_addr = nb_ff - 32'd4; state_in = S_MC5;
         end
         S_MC5: begin
            mreq.wr = 1'b1; mreq.byte_addr = nb_ff + dsz - 32'd8; mreq.wdata = msz_ff;
            mbp_in = pb_ff; state_in = S_MADD;
         end
         S_MADD: begin
            abp_in = mbp_ff; ret_add_in = ret_mg_ff; state_in = S_A0;
         end

         // unlink rbp from its list
         S_R0: begin
            mreq.rd = 1'b1; mreq.byte_addr = rbp_ff; state_in = S_R1;
         end
         S_R1: begin
            nx_in = rdata;
            mreq.rd = 1'b1; mreq.byte_addr = rbp_ff + 32'd4; state_in = S_R2;
         end
         S_R2: begin
            pv_in = rdata;
            mreq.rd = 1'b1; mreq.byte_addr = rbp_ff - 32'd4; state_in = S_R3;
         end
         S_R3: begin
            cls_in = d_cls;
            mreq.wr = 1'b1; mreq.byte_addr = rbp_ff; mreq.wdata = 32'd0;
            state_in = S_R4;
         end
         S_R4: begin
            mreq.wr = 1'b1; mreq.byte_addr = rbp_ff + 32'd4; mreq.wdata = 32'd0;
            state_in = S_R5;
         end
         S_R5: begin
            mreq.wr = 1'b1;
            priority if (nx_ff == 32'd0 && pv_ff == 32'd0) begin
               mreq.byte_addr = head_addr; mreq.wdata = 32'd0; state_in = ret_rm_ff;
            end else if (nx_ff == 32'd0) begin
               mreq.byte_addr = pv_ff; mreq.wdata = 32'd0; state_in = ret_rm_ff;
            end else if (pv_ff == 32'd0) begin
               mreq.byte_addr = head_addr; mreq.wdata = nx_ff; state_in = S_R6;
            end else begin
               mreq.byte_addr = pv_ff; mreq.wdata = nx_ff; state_in = S_R6;
            end
         end
         S_R6: begin
            mreq.wr = 1'b1; mreq.byte_addr = nx_ff + 32'd4; mreq.wdata = pv_ff;
            state_in = ret_rm_ff;
         end

         // push abp at the head of its list
         S_A0: begin
            mreq.rd = 1'b1; mreq.byte_addr = abp_ff - 32'd4; state_in = S_A1;
         end
         S_A1: begin
            cls_in = d_cls;
            mreq.rd = 1'b1; mreq.byte_addr = 32'({d_cls, 2'b00}); state_in = S_A2;
         end
         S_A2: begin
            first_in = rdata;
            mreq.wr = 1'b1; mreq.byte_addr = abp_ff + 32'd4; mreq.wdata = 32'd0;
            state_in = S_A3;
         end
         S_A3: begin
            mreq.wr = 1'b1; mreq.byte_addr = abp_ff; mreq.wdata = first_ff;
            state_in = S_A4;
         end
         S_A4: begin
            mreq.wr = (first_ff != 32'd0);
            mreq.byte_addr = first_ff + 32'd4; mreq.wdata = abp_ff;
            state_in = S_A5;
         end
         S_A5: begin
            mreq.wr = 1'b1; mreq.byte_addr = head_addr; mreq.wdata = abp_ff;
            state_in = ret_add_ff;
         end

         // hand the word to the response register
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_addr_in  = res_ff;
               rsp_st_in    = st_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ready_ff     <= 1'b0;
         brk_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ready_ff     <= ready_in;
         brk_ff       <= brk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      ret_rm_ff <= ret_rm_in;  ret_add_ff <= ret_add_in; ret_mg_ff <= ret_mg_in;
      gret_ff   <= gret_in;    cmd_ff     <= cmd_in;     st_ff     <= st_in;
      req_ff    <= req_in;     addr_ff    <= addr_in;    res_ff    <= res_in;
      asize_ff  <= asize_in;   pa_ff      <= pa_in;      cls_ff    <= cls_in;
      icnt_ff   <= icnt_in;    vis_ff     <= vis_in;     fbp_ff    <= fbp_in;
      cur_ff    <= cur_in;     rbp_ff     <= rbp_in;     nx_ff     <= nx_in;
      pv_ff     <= pv_in;      abp_ff     <= abp_in;     first_ff  <= first_in;
      mbp_ff    <= mbp_in;     pb_ff      <= pb_in;      nb_ff     <= nb_in;
      msz_ff    <= msz_in;     tmp_ff     <= tmp_in;     gsz_ff    <= gsz_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_st_ff   <= rsp_st_in;
   end

endmodule
